/* rtl/hbcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbcs_pkg
// Shared types, codes and the bucket hash fold for the hash bucket
// counting sort unit.
// ----------------------------------------------------------------------------
package hbcs_pkg;

  localparam int NUM_BUCKETS = 1024;
  localparam int MAX_KEYS    = 4096;
  localparam int BUCKET_BITS = $clog2(NUM_BUCKETS);
  localparam int KEY_BITS    = $clog2(MAX_KEYS);
  localparam int CNT_W       = 13;
  localparam int IDX_W       = 12;
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_BITS     = $clog2(CQ_DEPTH);

  localparam logic [31:0] RS_A = 32'd63689;
  localparam logic [31:0] RS_B = 32'd378551;

  localparam logic [BUCKET_BITS-1:0] TOP_BUCKET = BUCKET_BITS'(NUM_BUCKETS - 1);

  localparam logic [2:0] OP_KEY_BYTE    = 3'd0;
  localparam logic [2:0] OP_EMPTY_KEY   = 3'd1;
  localparam logic [2:0] OP_BUILD       = 3'd2;
  localparam logic [2:0] OP_READ_BUCKET = 3'd3;
  localparam logic [2:0] OP_READ_RANK   = 3'd4;
  localparam logic [2:0] OP_CLEAR       = 3'd5;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_KEY,
    CMD_BUILD,
    CMD_RD_BUCKET,
    CMD_RD_RANK,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [BUCKET_BITS-1:0] bucket;
    logic [IDX_W-1:0]       idx;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY_WR,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_SCAT_KEY,
    ST_SCAT_FILL,
    ST_SCAT_WR,
    ST_RD_BUCKET,
    ST_RD_RANK
  } back_state_t;

  // Remainder modulo 2^BUCKET_BITS - 1 by folding chunks.
  function automatic logic [BUCKET_BITS-1:0] rs_bucket(input logic [31:0] h);
    logic [BUCKET_BITS+2:0] s;
    logic [BUCKET_BITS:0]   t;
    s = '0;
    for (int k = 0; k < 32; k += BUCKET_BITS) begin
      s = s + (BUCKET_BITS+3)'((h >> k) & 32'(NUM_BUCKETS - 1));
    end
    t = (BUCKET_BITS+1)'(s[BUCKET_BITS-1:0]) + (BUCKET_BITS+1)'(s[BUCKET_BITS+2:BUCKET_BITS]);
    if (t >= (BUCKET_BITS+1)'(NUM_BUCKETS - 1)) begin
      t = t - (BUCKET_BITS+1)'(NUM_BUCKETS - 1);
    end
    return t[BUCKET_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/hbcs_cmd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbcs_cmd_fifo
// Short command queue between the classifying front and the sort engine.
// ----------------------------------------------------------------------------
module hbcs_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire hbcs_pkg::cmd_t wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output hbcs_pkg::cmd_t     rd_data,
  output logic               empty
);

  hbcs_pkg::cmd_t                entries [hbcs_pkg::CQ_DEPTH];
  logic [hbcs_pkg::CQ_BITS-1:0]  wr_ptr;
  logic [hbcs_pkg::CQ_BITS-1:0]  rd_ptr;
  logic [hbcs_pkg::CQ_BITS:0]    count;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (count == (hbcs_pkg::CQ_BITS+1)'(hbcs_pkg::CQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/hbcs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbcs_front
// Accepts transactions, runs the RS hash over key bytes and classifies each
// transaction into a command with its bucket number for the engine.
// ----------------------------------------------------------------------------
module hbcs_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  key_byte,
  input  wire logic        key_end,
  input  wire logic [11:0] read_index,
  output logic             busy,
  input  wire logic        q_full,
  output logic             q_push,
  output hbcs_pkg::cmd_t   q_data
);

  logic [31:0]               hash_accum;
  logic [31:0]               hash_mult;
  logic                      s2_valid;
  hbcs_pkg::cmd_kind_t       s2_kind;
  logic [31:0]               s2_hash;
  logic [hbcs_pkg::IDX_W-1:0] s2_idx;
  logic [31:0]               sx;
  logic [31:0]               prod;
  logic [31:0]               mult_step;

  assign sx        = {{24{key_byte[7]}}, key_byte};
  assign prod      = hash_accum * hash_mult + sx;
  assign mult_step = hash_mult * hbcs_pkg::RS_B;

  assign busy          = s2_valid && q_full;
  assign q_push        = s2_valid;
  assign q_data.kind   = s2_kind;
  assign q_data.bucket = hbcs_pkg::rs_bucket(s2_hash);
  assign q_data.idx    = s2_idx;

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_idx  <= read_index;
      s2_hash <= '0;
      s2_kind <= hbcs_pkg::CMD_NOP;
      case (operation)
        hbcs_pkg::OP_KEY_BYTE: begin
          if (key_end) begin
            s2_kind <= hbcs_pkg::CMD_KEY;
            s2_hash <= prod;
          end
        end
        hbcs_pkg::OP_EMPTY_KEY:   s2_kind <= hbcs_pkg::CMD_KEY;
        hbcs_pkg::OP_BUILD:       s2_kind <= hbcs_pkg::CMD_BUILD;
        hbcs_pkg::OP_READ_BUCKET: s2_kind <= hbcs_pkg::CMD_RD_BUCKET;
        hbcs_pkg::OP_READ_RANK:   s2_kind <= hbcs_pkg::CMD_RD_RANK;
        hbcs_pkg::OP_CLEAR:       s2_kind <= hbcs_pkg::CMD_CLEAR;
        default:                  s2_kind <= hbcs_pkg::CMD_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      hash_accum <= '0;
      hash_mult  <= hbcs_pkg::RS_A;
    end else begin
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (!q_full) begin
        s2_valid <= 1'b0;
      end
      if (accept) begin
        case (operation)
          hbcs_pkg::OP_KEY_BYTE: begin
            if (key_end) begin
              hash_accum <= '0;
              hash_mult  <= hbcs_pkg::RS_A;
            end else begin
              hash_accum <= prod;
              hash_mult  <= mult_step;
            end
          end
          hbcs_pkg::OP_EMPTY_KEY, hbcs_pkg::OP_CLEAR: begin
            hash_accum <= '0;
            hash_mult  <= hbcs_pkg::RS_A;
          end
          default: begin
            hash_accum <= hash_accum;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/hbcs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbcs_back
// Sort engine: bucket counts, prefix-sum build, stable scatter into the rank
// table, reads, clearing sweep and the result register.
// ----------------------------------------------------------------------------
module hbcs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire hbcs_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                init_busy,
  output logic                empty,
  input  wire logic           pop,
  output logic [12:0]         read_value,
  output logic [12:0]         bucket_count,
  output logic                bucket_used,
  output logic [12:0]         key_total,
  output logic [1:0]          status
);

  localparam int BB = hbcs_pkg::BUCKET_BITS;
  localparam int KB = hbcs_pkg::KEY_BITS;
  localparam int CW = hbcs_pkg::CNT_W;

  hbcs_pkg::back_state_t state, state_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] run, run_next;
  logic [CW-1:0] kc, kc_next;
  logic [BB-1:0] sb, sb_next;
  logic          clr_res, clr_res_next;
  logic          o_valid, o_valid_next;
  logic [CW-1:0] o_value, o_value_next;
  logic [CW-1:0] o_count, o_count_next;
  logic          o_used, o_used_next;
  logic [1:0]    o_status, o_status_next;

  logic [CW-1:0] cnt_mem [hbcs_pkg::NUM_BUCKETS];
  logic          cnt_we;
  logic [BB-1:0] cnt_wa, cnt_ra;
  logic [CW-1:0] cnt_wd, cnt_q;

  logic [CW-1:0] st_mem [hbcs_pkg::NUM_BUCKETS];
  logic          st_we;
  logic [BB-1:0] st_wa, st_ra;
  logic [CW-1:0] st_wd, st_q;

  logic [CW-1:0] fl_mem [hbcs_pkg::NUM_BUCKETS];
  logic          fl_we;
  logic [BB-1:0] fl_wa, fl_ra;
  logic [CW-1:0] fl_wd, fl_q;

  logic [BB-1:0] kb_mem [hbcs_pkg::MAX_KEYS];
  logic          kb_we;
  logic [KB-1:0] kb_wa, kb_ra;
  logic [BB-1:0] kb_wd, kb_q;

  logic [KB-1:0] rk_mem [hbcs_pkg::MAX_KEYS];
  logic          rk_we;
  logic [KB-1:0] rk_wa, rk_ra;
  logic [KB-1:0] rk_wd, rk_q;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    st_q <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_wa] <= fl_wd;
    end
    fl_q <= fl_mem[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (kb_we) begin
      kb_mem[kb_wa] <= kb_wd;
    end
    kb_q <= kb_mem[kb_ra];
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rk_wa] <= rk_wd;
    end
    rk_q <= rk_mem[rk_ra];
  end

  assign init_busy    = (state == hbcs_pkg::ST_CLEAR) && !clr_res;
  assign empty        = !o_valid;
  assign read_value   = o_value;
  assign bucket_count = o_count;
  assign bucket_used  = o_used;
  assign status       = o_status;
  assign key_total    = kc;

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    run_next      = run;
    kc_next       = kc;
    sb_next       = sb;
    clr_res_next  = clr_res;
    o_valid_next  = o_valid && !pop;
    o_value_next  = o_value;
    o_count_next  = o_count;
    o_used_next   = o_used;
    o_status_next = o_status;
    cmd_pop       = 1'b0;
    cnt_we = 1'b0; cnt_wa = ptr[BB-1:0]; cnt_wd = '0; cnt_ra = ptr[BB-1:0];
    st_we  = 1'b0; st_wa  = ptr[BB-1:0]; st_wd  = '0; st_ra  = cmd.idx[BB-1:0];
    fl_we  = 1'b0; fl_wa  = ptr[BB-1:0]; fl_wd  = '0; fl_ra  = kb_q;
    kb_we  = 1'b0; kb_wa  = kc[KB-1:0];  kb_wd  = sb; kb_ra  = ptr[KB-1:0];
    rk_we  = 1'b0; rk_wa  = fl_q[KB-1:0]; rk_wd = ptr[KB-1:0]; rk_ra = cmd.idx[KB-1:0];
    case (state)
      hbcs_pkg::ST_CLEAR: begin
        cnt_we   = 1'b1;
        st_we    = 1'b1;
        ptr_next = ptr + 1'b1;
        if (ptr[BB-1:0] == hbcs_pkg::TOP_BUCKET) begin
          ptr_next = '0;
          if (clr_res) begin
            o_valid_next  = 1'b1;
            o_value_next  = '0;
            o_count_next  = '0;
            o_used_next   = 1'b0;
            o_status_next = hbcs_pkg::STS_OK;
          end
          clr_res_next = 1'b0;
          state_next   = hbcs_pkg::ST_IDLE;
        end
      end
      hbcs_pkg::ST_IDLE: begin
        if (cmd_valid && !o_valid) begin
          cmd_pop       = 1'b1;
          o_value_next  = '0;
          o_count_next  = '0;
          o_used_next   = 1'b0;
          o_status_next = hbcs_pkg::STS_OK;
          case (cmd.kind)
            hbcs_pkg::CMD_KEY: begin
              if (kc >= CW'(hbcs_pkg::MAX_KEYS)) begin
                o_valid_next  = 1'b1;
                o_status_next = hbcs_pkg::STS_FULL;
              end else begin
                cnt_ra     = cmd.bucket;
                sb_next    = cmd.bucket;
                state_next = hbcs_pkg::ST_KEY_WR;
              end
            end
            hbcs_pkg::CMD_BUILD: begin
              ptr_next   = '0;
              run_next   = '0;
              state_next = hbcs_pkg::ST_SCAN_RD;
            end
            hbcs_pkg::CMD_RD_BUCKET: begin
              if ({1'b0, cmd.idx} >= CW'(hbcs_pkg::NUM_BUCKETS)) begin
                o_valid_next  = 1'b1;
                o_status_next = hbcs_pkg::STS_RANGE;
              end else begin
                cnt_ra     = cmd.idx[BB-1:0];
                state_next = hbcs_pkg::ST_RD_BUCKET;
              end
            end
            hbcs_pkg::CMD_RD_RANK: begin
              if ({1'b0, cmd.idx} >= kc) begin
                o_valid_next  = 1'b1;
                o_status_next = hbcs_pkg::STS_RANGE;
              end else begin
                state_next = hbcs_pkg::ST_RD_RANK;
              end
            end
            hbcs_pkg::CMD_CLEAR: begin
              kc_next      = '0;
              ptr_next     = '0;
              clr_res_next = 1'b1;
              state_next   = hbcs_pkg::ST_CLEAR;
            end
            default: begin
              o_valid_next = 1'b1;
            end
          endcase
        end
      end
      hbcs_pkg::ST_KEY_WR: begin
        cnt_we       = 1'b1;
        cnt_wa       = sb;
        cnt_wd       = cnt_q + 1'b1;
        kb_we        = 1'b1;
        kc_next      = kc + 1'b1;
        o_valid_next = 1'b1;
        state_next   = hbcs_pkg::ST_IDLE;
      end
      hbcs_pkg::ST_SCAN_RD: begin
        state_next = hbcs_pkg::ST_SCAN_WR;
      end
      hbcs_pkg::ST_SCAN_WR: begin
        st_we    = 1'b1;
        fl_we    = 1'b1;
        st_wd    = (ptr[BB-1:0] == hbcs_pkg::TOP_BUCKET) ? '0 : run;
        fl_wd    = st_wd;
        run_next = run + cnt_q;
        if (ptr[BB-1:0] == hbcs_pkg::TOP_BUCKET) begin
          ptr_next   = '0;
          state_next = hbcs_pkg::ST_SCAT_KEY;
        end else begin
          ptr_next   = ptr + 1'b1;
          state_next = hbcs_pkg::ST_SCAN_RD;
        end
      end
      hbcs_pkg::ST_SCAT_KEY: begin
        if (ptr == kc) begin
          o_valid_next = 1'b1;
          state_next   = hbcs_pkg::ST_IDLE;
        end else begin
          state_next = hbcs_pkg::ST_SCAT_FILL;
        end
      end
      hbcs_pkg::ST_SCAT_FILL: begin
        sb_next    = kb_q;
        state_next = hbcs_pkg::ST_SCAT_WR;
      end
      hbcs_pkg::ST_SCAT_WR: begin
        rk_we      = (fl_q < CW'(hbcs_pkg::MAX_KEYS));
        fl_we      = 1'b1;
        fl_wa      = sb;
        fl_wd      = fl_q + 1'b1;
        ptr_next   = ptr + 1'b1;
        state_next = hbcs_pkg::ST_SCAT_KEY;
      end
      hbcs_pkg::ST_RD_BUCKET: begin
        o_valid_next = 1'b1;
        o_value_next = st_q;
        o_count_next = cnt_q;
        o_used_next  = (cnt_q != '0);
        state_next   = hbcs_pkg::ST_IDLE;
      end
      hbcs_pkg::ST_RD_RANK: begin
        o_valid_next = 1'b1;
        o_value_next = {1'b0, rk_q};
        state_next   = hbcs_pkg::ST_IDLE;
      end
      default: begin
        state_next = hbcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    run      <= run_next;
    sb       <= sb_next;
    o_value  <= o_value_next;
    o_count  <= o_count_next;
    o_used   <= o_used_next;
    o_status <= o_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hbcs_pkg::ST_CLEAR;
      ptr     <= '0;
      kc      <= '0;
      clr_res <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      kc      <= kc_next;
      clr_res <= clr_res_next;
      o_valid <= o_valid_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/hash_bucket_counting_sort_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hash_bucket_counting_sort_unit
// RS-hash bucket counter with prefix-sum build and counting-sort rank table.
// ----------------------------------------------------------------------------
// Every transaction yields one result. The front hashes one key byte per
// cycle while full is low and holds up to four queued commands plus one in
// flight, so it takes a transaction every cycle until that space fills. The
// engine takes the next command only after the previous result has been
// popped. A build makes two passes through the bucket and key memories, and
// a clear sweeps the bucket count and start memories. After reset the same
// sweep runs with full held high.
// ----------------------------------------------------------------------------
module hash_bucket_counting_sort_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  key_byte,
  input  wire logic        key_end,
  input  wire logic [11:0] read_index,
  output logic             empty,
  input  wire logic        pop,
  output logic [12:0]      read_value,
  output logic [12:0]      bucket_count,
  output logic             bucket_used,
  output logic [12:0]      key_total,
  output logic [1:0]       status
);

  logic           front_busy;
  logic           init_busy;
  logic           q_push;
  logic           q_full;
  hbcs_pkg::cmd_t q_wdata;
  hbcs_pkg::cmd_t q_rdata;
  logic           q_empty;
  logic           q_pop;

  assign full = front_busy || init_busy;

  hbcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (push && !full),
    .operation  (operation),
    .key_byte   (key_byte),
    .key_end    (key_end),
    .read_index (read_index),
    .busy       (front_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  hbcs_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  hbcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!q_empty),
    .cmd          (q_rdata),
    .cmd_pop      (q_pop),
    .init_busy    (init_busy),
    .empty        (empty),
    .pop          (pop),
    .read_value   (read_value),
    .bucket_count (bucket_count),
    .bucket_used  (bucket_used),
    .key_total    (key_total),
    .status       (status)
  );

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    key_total <= 13'(hbcs_pkg::MAX_KEYS))
    else $error("key total beyond table size");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    (key_total != $past(key_total)) |->
      (key_total == $past(key_total) + 13'd1 || key_total == 13'd0))
    else $error("key total jumped");

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && bucket_used) |-> (bucket_count != 13'd0 && status == hbcs_pkg::STS_OK))
    else $error("used bucket without count");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == hbcs_pkg::STS_OK || status == hbcs_pkg::STS_FULL ||
                status == hbcs_pkg::STS_RANGE))
    else $error("bad status code");

endmodule
`default_nettype wire
